// ===== rtl/core/ndvi_pkg.sv =====
// Shared constants, register codes and types of the NDVI pseudocolor pipeline.
`timescale 1ns / 1ps

package ndvi_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int GAIN_W     = 7;
  localparam int BRI_W      = 8;
  localparam int LIM_W      = 11;
  localparam int BYTE_W     = 8;
  localparam int OFF_W      = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_CONTRAST   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLUE_BRIGHTNESS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_CONTRAST    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_BRIGHTNESS  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BAND_ENABLE     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BAND_LOW        = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BAND_HIGH       = 3'd6;

  localparam logic [GAIN_W-1:0]       RST_BLUE_CONTRAST   = 7'd50;
  localparam logic [BRI_W-1:0]        RST_BLUE_BRIGHTNESS = 8'd0;
  localparam logic [GAIN_W-1:0]       RST_RED_CONTRAST    = 7'd50;
  localparam logic [BRI_W-1:0]        RST_RED_BRIGHTNESS  = 8'd130;
  localparam logic signed [LIM_W-1:0] RST_BAND_LOW        = 11'sd300;
  localparam logic signed [LIM_W-1:0] RST_BAND_HIGH       = 11'sd700;

  localparam int PCT        = 100;
  localparam int BRI_BIAS   = 50;
  localparam int MIN_SUM    = 100;
  localparam int KILO       = 1000;
  localparam int GRAY_SCALE = 127;

  localparam int QUO_BITS = BYTE_W;
  localparam int DIV_BPS  = 2;

  localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_HALF = 8'h80;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic rej;
  } div_flags_t;

endpackage

// ===== rtl/core/ndvi_ifs.sv =====
// Valid/ready channel interfaces for pixels, results and register writes.
`timescale 1ns / 1ps

interface ndvi_pix_if #(parameter int PIXEL_BITS = 8) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] blue_in;
  logic [PIXEL_BITS-1:0] red_in;

  modport source (output valid, output blue_in, output red_in, input ready);
  modport sink   (input valid, input blue_in, input red_in, output ready);
endinterface

interface ndvi_res_if import ndvi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] gray_level;
  logic [BYTE_W-1:0] color_red;
  logic [BYTE_W-1:0] color_green;
  logic [BYTE_W-1:0] color_blue;
  logic              band_rejected;

  modport source (output valid, output gray_level, output color_red, output color_green,
                  output color_blue, output band_rejected, input ready);
  modport sink   (input valid, input gray_level, input color_red, input color_green,
                  input color_blue, input band_rejected, output ready);
endinterface

interface ndvi_cfg_if import ndvi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/core/ndvi_div.sv =====
// Pipelined restoring divider with round-half-even and byte saturation.
`timescale 1ns / 1ps

module ndvi_div import ndvi_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIXEL_BITS+16:0]  rem_in,
  input  logic [PIXEL_BITS+8:0]   dvs_in,
  input  div_flags_t              flags_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [BYTE_W-1:0]       gray_out,
  output logic                    rej_out
);

  localparam int RW     = PIXEL_BITS + 17;
  localparam int UW     = PIXEL_BITS + 9;
  localparam int QW     = QUO_BITS;
  localparam int STAGES = QW / DIV_BPS;

  logic [RW-1:0]    rem_r [1:STAGES];
  logic [UW-1:0]    dvs_r [1:STAGES];
  logic [QW-1:0]    q_r   [1:STAGES];
  div_flags_t       fl_r  [1:STAGES];
  logic [STAGES+1:1] v_r;

  logic [RW-1:0]    rem_a [0:STAGES];
  logic [UW-1:0]    dvs_a [0:STAGES];
  logic [QW-1:0]    q_a   [0:STAGES];
  div_flags_t       fl_a  [0:STAGES];
  logic [STAGES:0]  v_a;

  logic [RW-1:0]    rem_nxt [1:STAGES];
  logic [QW-1:0]    q_nxt   [1:STAGES];
  logic [STAGES+1:1] adv;

  logic [BYTE_W-1:0] gray_r, gray_nxt;
  logic              rej_r;
  logic [UW:0]       twice;
  logic              round_up;

  always_comb begin
    rem_a[0] = rem_in;
    dvs_a[0] = dvs_in;
    q_a[0]   = '0;
    fl_a[0]  = flags_in;
    v_a[0]   = in_valid;
    for (int k = 1; k <= STAGES; k++) begin
      rem_a[k] = rem_r[k];
      dvs_a[k] = dvs_r[k];
      q_a[k]   = q_r[k];
      fl_a[k]  = fl_r[k];
      v_a[k]   = v_r[k];
    end
  end

  always_comb begin
    adv[STAGES+1] = !v_r[STAGES+1] || out_ready;
    for (int k = STAGES; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1];

  always_comb begin
    logic [RW-1:0] rem;
    logic [RW-1:0] trial;
    logic [QW-1:0] q;
    for (int k = 1; k <= STAGES; k++) begin
      rem = rem_a[k-1];
      q   = q_a[k-1];
      for (int b = 0; b < DIV_BPS; b++) begin
        trial = RW'(dvs_a[k-1]) << (QW - 1 - (k - 1) * DIV_BPS - b);
        if (rem >= trial) begin
          rem = rem - trial;
          q[QW - 1 - (k - 1) * DIV_BPS - b] = 1'b1;
        end
      end
      rem_nxt[k] = rem;
      q_nxt[k]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= STAGES + 1; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_a[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= STAGES; k++) begin
      if (adv[k]) begin
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_a[k-1];
        q_r[k]   <= q_nxt[k];
        fl_r[k]  <= fl_a[k-1];
      end
    end
  end

  always_comb begin
    twice    = {rem_r[STAGES][UW-1:0], 1'b0};
    round_up = (twice > {1'b0, dvs_r[STAGES]}) ||
               ((twice == {1'b0, dvs_r[STAGES]}) && q_r[STAGES][0]);
    if (fl_r[STAGES].rej || fl_r[STAGES].neg) begin
      gray_nxt = '0;
    end else if (fl_r[STAGES].ovf) begin
      gray_nxt = BYTE_MAX;
    end else if (round_up && (q_r[STAGES] != BYTE_MAX)) begin
      gray_nxt = q_r[STAGES] + 1'b1;
    end else begin
      gray_nxt = q_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[STAGES+1]) begin
      gray_r <= gray_nxt;
      rej_r  <= fl_r[STAGES].rej;
    end
  end

  assign out_valid = v_r[STAGES+1];
  assign gray_out  = gray_r;
  assign rej_out   = rej_r;

endmodule

// ===== rtl/core/ndvi_pixel_pseudocolor.sv =====
// Top level of the NDVI pseudocolor pixel pipeline.
//
//   channel  | dir | handshake            | request payload
//   ---------+-----+----------------------+---------------------------------------------
//   in_pix   | in  | valid / ready        | blue_in, red_in
//   out_pix  | out | valid / ready        | gray_level, color_red/green/blue, band_rejected
//   cfg_wr   | in  | valid / ready (=1)   | addr, data
//
// One request per cycle while out_pix is not stalled.
// Stages: adjust, sum/difference, band and gray products, range checks,
// four divider stages of two quotient bits each, rounding, pseudocolor.
// Reset clears every valid bit and loads the register defaults.
// Each stage holds while the next is full and stalled; empty stages fill.
`timescale 1ns / 1ps

module ndvi_pixel_pseudocolor import ndvi_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  ndvi_pix_if.sink   in_pix,
  ndvi_res_if.source out_pix,
  ndvi_cfg_if.sink   cfg_wr
);

  localparam int PROD_W = PIXEL_BITS + GAIN_W;
  localparam int AW     = PIXEL_BITS + 9;
  localparam int SW     = PIXEL_BITS + 10;
  localparam int UW     = PIXEL_BITS + 9;
  localparam int PW     = PIXEL_BITS + 21;
  localparam int NW     = PIXEL_BITS + 18;
  localparam int RW     = NW - 1;

  logic [GAIN_W-1:0]       blue_contrast_r, red_contrast_r;
  logic [BRI_W-1:0]        blue_brightness_r, red_brightness_r;
  logic                    band_enable_r;
  logic signed [LIM_W-1:0] band_low_r, band_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_contrast_r   <= RST_BLUE_CONTRAST;
      blue_brightness_r <= RST_BLUE_BRIGHTNESS;
      red_contrast_r    <= RST_RED_CONTRAST;
      red_brightness_r  <= RST_RED_BRIGHTNESS;
      band_enable_r     <= 1'b0;
      band_low_r        <= RST_BAND_LOW;
      band_high_r       <= RST_BAND_HIGH;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.addr)
        REG_BLUE_CONTRAST:   blue_contrast_r   <= cfg_wr.data[GAIN_W-1:0];
        REG_BLUE_BRIGHTNESS: blue_brightness_r <= cfg_wr.data[BRI_W-1:0];
        REG_RED_CONTRAST:    red_contrast_r    <= cfg_wr.data[GAIN_W-1:0];
        REG_RED_BRIGHTNESS:  red_brightness_r  <= cfg_wr.data[BRI_W-1:0];
        REG_BAND_ENABLE:     band_enable_r     <= cfg_wr.data[0];
        REG_BAND_LOW:        band_low_r        <= $signed(cfg_wr.data[LIM_W-1:0]);
        REG_BAND_HIGH:       band_high_r       <= $signed(cfg_wr.data[LIM_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg_wr.ready = 1'b1;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic adv1, adv2, adv3, adv4, adv_o;
  logic div_in_ready, div_out_valid, div_out_ready;

  assign adv_o         = !vo_r || out_pix.ready;
  assign div_out_ready = adv_o;
  assign adv4          = !v4_r || div_in_ready;
  assign adv3          = !v3_r || adv4;
  assign adv2          = !v2_r || adv3;
  assign adv1          = !v2_r || adv2 ? (!v1_r || adv2) : !v1_r;
  assign in_pix.ready  = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_pix.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv_o) vo_r <= div_out_valid;
    end
  end

  // adjust both bands: value*contrast + (brightness-50)*100
  logic [PROD_W-1:0]        pb_mul, pr_mul;
  logic signed [OFF_W-1:0]  boff, roff;
  logic signed [AW-1:0]     s1_ab_nxt, s1_ar_nxt, s1_ab_r, s1_ar_r;

  always_comb begin
    pb_mul    = PROD_W'(in_pix.blue_in[PIXEL_BITS-1:0]) * PROD_W'(blue_contrast_r);
    pr_mul    = PROD_W'(in_pix.red_in[PIXEL_BITS-1:0]) * PROD_W'(red_contrast_r);
    boff      = OFF_W'(blue_brightness_r) * OFF_W'(PCT) - OFF_W'(BRI_BIAS * PCT);
    roff      = OFF_W'(red_brightness_r) * OFF_W'(PCT) - OFF_W'(BRI_BIAS * PCT);
    s1_ab_nxt = AW'($signed({1'b0, pb_mul})) + AW'(boff);
    s1_ar_nxt = AW'($signed({1'b0, pr_mul})) + AW'(roff);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_ab_r <= s1_ab_nxt;
      s1_ar_r <= s1_ar_nxt;
    end
  end

  // sum clamped to at least 100, and difference
  logic signed [SW-1:0] sum, s2_d_nxt, s2_d_r;
  logic [UW-1:0]        s2_s_nxt, s2_s_r;

  always_comb begin
    sum      = SW'(s1_ar_r) + SW'(s1_ab_r);
    s2_d_nxt = SW'(s1_ar_r) - SW'(s1_ab_r);
    if (sum < SW'(MIN_SUM)) begin
      s2_s_nxt = UW'(MIN_SUM);
    end else begin
      s2_s_nxt = sum[UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_d_r <= s2_d_nxt;
      s2_s_r <= s2_s_nxt;
    end
  end

  // band products and gray numerator (d+s)*127
  logic signed [PW-1:0] s_ext;
  logic signed [NW-1:0] ds;
  logic signed [PW-1:0] s3_dk_nxt, s3_lo_nxt, s3_hi_nxt, s3_dk_r, s3_lo_r, s3_hi_r;
  logic signed [NW-1:0] s3_n_nxt, s3_n_r;
  logic [UW-1:0]        s3_s_r;

  always_comb begin
    s_ext     = PW'($signed({1'b0, s2_s_r}));
    s3_dk_nxt = PW'(s2_d_r) * PW'(KILO);
    s3_lo_nxt = PW'(band_low_r) * s_ext;
    s3_hi_nxt = PW'(band_high_r) * s_ext;
    ds        = NW'(s2_d_r) + NW'($signed({1'b0, s2_s_r}));
    s3_n_nxt  = ds * NW'(GRAY_SCALE);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_dk_r <= s3_dk_nxt;
      s3_lo_r <= s3_lo_nxt;
      s3_hi_r <= s3_hi_nxt;
      s3_n_r  <= s3_n_nxt;
      s3_s_r  <= s2_s_r;
    end
  end

  // band test and divider range checks
  div_flags_t    s4_fl_nxt, s4_fl_r;
  logic [RW-1:0] s4_rem_r;
  logic [UW-1:0] s4_s_r;

  always_comb begin
    s4_fl_nxt.rej = band_enable_r && ((s3_dk_r < s3_lo_r) || (s3_dk_r > s3_hi_r));
    s4_fl_nxt.neg = s3_n_r[NW-1];
    s4_fl_nxt.ovf = !s3_n_r[NW-1] && (s3_n_r[RW-1:0] >= {s3_s_r, {QUO_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_fl_r  <= s4_fl_nxt;
      s4_rem_r <= s3_n_r[RW-1:0];
      s4_s_r   <= s3_s_r;
    end
  end

  logic [BYTE_W-1:0] div_gray;
  logic              div_rej;

  ndvi_div #(.PIXEL_BITS(PIXEL_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_ready  (div_in_ready),
    .rem_in    (s4_rem_r),
    .dvs_in    (s4_s_r),
    .flags_in  (s4_fl_r),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .gray_out  (div_gray),
    .rej_out   (div_rej)
  );

  // pseudocolor from the gray byte
  logic [BYTE_W-1:0] inv, cr_nxt, cb_nxt, cg_nxt;
  logic [BYTE_W:0]   csum;
  logic [BYTE_W-1:0] gray_r, cr_r, cg_r, cb_r;
  logic              rej_r;

  always_comb begin
    inv    = BYTE_MAX - div_gray;
    cr_nxt = (div_gray > BYTE_HALF) ? {div_gray[BYTE_W-2:0], 1'b0} : '0;
    cb_nxt = (inv > BYTE_HALF) ? {inv[BYTE_W-2:0], 1'b0} : '0;
    csum   = {1'b0, cr_nxt} + {1'b0, cb_nxt};
    cg_nxt = csum[BYTE_W] ? '0 : (BYTE_MAX - csum[BYTE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      gray_r <= div_gray;
      cr_r   <= cr_nxt;
      cg_r   <= cg_nxt;
      cb_r   <= cb_nxt;
      rej_r  <= div_rej;
    end
  end

  assign out_pix.valid         = vo_r;
  assign out_pix.gray_level    = gray_r;
  assign out_pix.color_red     = cr_r;
  assign out_pix.color_green   = cg_r;
  assign out_pix.color_blue    = cb_r;
  assign out_pix.band_rejected = rej_r;

endmodule

// ===== rtl/core/ndvi_chk.sv =====
// Port checker for the NDVI pseudocolor pipeline and its bind.
`timescale 1ns / 1ps

module ndvi_chk import ndvi_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] gray_level,
  input logic [BYTE_W-1:0] color_red,
  input logic [BYTE_W-1:0] color_green,
  input logic [BYTE_W-1:0] color_blue,
  input logic              band_rejected
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(gray_level) &&
      $stable(color_red) && $stable(color_green) && $stable(color_blue) &&
      $stable(band_rejected))
    else $error("stalled result request changed");

  a_reject_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && band_rejected |-> gray_level == '0)
    else $error("rejected pixel with nonzero gray");

  a_color_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (color_red == '0 || color_blue == '0) &&
      (color_green == BYTE_MAX - color_red - color_blue))
    else $error("pseudocolor channels inconsistent");

endmodule

bind ndvi_pixel_pseudocolor ndvi_chk u_ndvi_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_pix.valid),
  .out_ready     (out_pix.ready),
  .gray_level    (out_pix.gray_level),
  .color_red     (out_pix.color_red),
  .color_green   (out_pix.color_green),
  .color_blue    (out_pix.color_blue),
  .band_rejected (out_pix.band_rejected)
);
